// ===== hw/rtl/rap_pkg.sv =====
// rap_pkg: types, codes and constants for the resource archive parser
// used by every module of the block; no dependencies
`default_nettype none

package rap_pkg;

	localparam int QUEUE_DEPTH = 4;

	localparam logic [7:0] SIG_BYTE0 = 8'h00;
	localparam logic [7:0] SIG_BYTE1 = 8'h45;
	localparam logic [7:0] SIG_BYTE2 = 8'h52;
	localparam logic [7:0] SIG_BYTE3 = 8'h4D;

	localparam logic [1:0] LEAD_TYPE = 2'b00;
	localparam logic [1:0] LEAD_RID  = 2'b01;
	localparam logic [1:0] LEAD_LEN  = 2'b10;

	typedef enum logic [2:0] {
		PH_SIG  = 3'd0,
		PH_LEAD = 3'd1,
		PH_RID  = 3'd2,
		PH_LEN1 = 3'd3,
		PH_LEN2 = 3'd4,
		PH_DATA = 3'd5,
		PH_DONE = 3'd6,
		PH_HALT = 3'd7
	} phase_t;

	typedef enum logic [1:0] {
		KIND_DATA  = 2'd0,
		KIND_END   = 2'd1,
		KIND_ERROR = 2'd2
	} kind_t;

	typedef enum logic [2:0] {
		ERR_SIG   = 3'd0,
		ERR_TRUNC = 3'd1,
		ERR_TYPE  = 3'd2,
		ERR_ID    = 3'd3,
		ERR_LEAD  = 3'd4
	} err_t;

	typedef struct packed {
		logic [7:0] stream_byte;
		logic       final_byte;
	} item_t;

	typedef struct packed {
		kind_t       kind;
		logic [7:0]  type_id;
		logic [15:0] resource_id;
		logic [7:0]  data_byte;
		logic        first_of_resource;
		logic        last_of_resource;
		logic [22:0] resource_length;
		err_t        error_code;
	} result_t;

	// one queue entry: a primary result and an optional trailing error
	typedef struct packed {
		kind_t       kind;
		logic [7:0]  type_id;
		logic [15:0] res1;
		logic [7:0]  data_byte;
		logic        first;
		logic        last;
		logic [22:0] length;
		err_t        err;
		logic        two;
		logic [15:0] res2;
		err_t        err2;
	} entry_t;

	function automatic logic [7:0] sig_byte(input logic [1:0] idx);
		logic [7:0] v;
		case (idx)
			2'd0: v = SIG_BYTE0;
			2'd1: v = SIG_BYTE1;
			2'd2: v = SIG_BYTE2;
			2'd3: v = SIG_BYTE3;
			default: v = SIG_BYTE0;
		endcase
		return v;
	endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/resource_archive_parser.sv =====
// resource archive parser: one archive byte per item, payload bytes and status out
// a result passes through the queue and then the output register before it is valid
// throughput: one item per cycle unless item_stall; one result per cycle unless result_stall
// two results for a payload byte that ends in error; such an item holds the queue head for both
// reset: arst_n clears the queue and the output valid and returns parsing to the signature
`default_nettype none

module resource_archive_parser #(
	parameter int QueueDepth = rap_pkg::QUEUE_DEPTH
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             item_valid,
	output logic                  item_stall,
	input  wire rap_pkg::item_t   item,
	output logic                  result_valid,
	input  wire logic             result_stall,
	output rap_pkg::result_t      result
);

	logic            accept;
	logic            push;
	rap_pkg::entry_t push_entry;
	logic            pop;
	rap_pkg::entry_t head;
	logic            q_empty;
	logic            q_full;

	assign item_stall = q_full;
	assign accept     = item_valid && !q_full;

	rap_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.accept     (accept),
		.item       (item),
		.push       (push),
		.push_entry (push_entry)
	);

	rap_queue #(
		.Depth (QueueDepth)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_entry (push_entry),
		.pop        (pop),
		.head       (head),
		.empty      (q_empty),
		.full       (q_full)
	);

	rap_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.head         (head),
		.empty        (q_empty),
		.pop          (pop),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result)
	);

	a_nondata_clean: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.kind != rap_pkg::KIND_DATA |->
			result.data_byte == 8'h00 && !result.first_of_resource &&
			!result.last_of_resource && result.resource_length == 23'd0)
		else $error("non-payload result carries payload fields");

	a_single_byte: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.kind == rap_pkg::KIND_DATA &&
			result.first_of_resource && result.last_of_resource |->
			result.resource_length == 23'd1)
		else $error("first and last on a resource longer than one byte");

	a_data_len: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.kind == rap_pkg::KIND_DATA |->
			result.resource_length != 23'd0)
		else $error("payload byte with zero resource length");

	a_push_space: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !q_full)
		else $error("entry pushed into a full queue");

endmodule

`default_nettype wire

// ===== hw/rtl/rap_front.sv =====
// rap_front: byte parser; tracks archive state and builds queue entries
// depends on rap_pkg
`default_nettype none

module rap_front (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            accept,
	input  wire rap_pkg::item_t  item,
	output logic                 push,
	output rap_pkg::entry_t      push_entry
);

	rap_pkg::phase_t phase_q, phase_d;
	logic [1:0]  cnt_q, cnt_d;
	logic [7:0]  type_q, type_d;
	logic [15:0] res_q, res_d;
	logic [13:0] hdr_q, hdr_d;
	logic [22:0] left_q, left_d;
	logic [22:0] len_q, len_d;
	logic        push_raw;
	rap_pkg::entry_t ent;

	logic [7:0]  b;
	logic        fin;
	logic        sig_ok;
	logic [8:0]  type_sum;
	logic [16:0] rid_sum;
	logic [16:0] res_inc;
	logic [22:0] len_new;
	logic        is_first;
	logic        is_last;

	assign b        = item.stream_byte;
	assign fin      = item.final_byte;
	assign sig_ok   = (b == rap_pkg::sig_byte(cnt_q));
	assign type_sum = {1'b0, type_q} + {1'b0, b};
	assign rid_sum  = {1'b0, res_q} + {3'b000, hdr_q[5:0], b} + 17'd1;
	assign res_inc  = {1'b0, res_q} + 17'd1;
	assign len_new  = {1'b0, hdr_q, b} + 23'd1;
	assign is_first = (left_q == len_q);
	assign is_last  = (left_q <= 23'd1);

	// next phase
	always_comb begin
		phase_d = phase_q;
		case (phase_q)
			rap_pkg::PH_SIG: begin
				if (!sig_ok || fin) begin
					phase_d = rap_pkg::PH_HALT;
				end else if (cnt_q == 2'd3) begin
					phase_d = rap_pkg::PH_LEAD;
				end
			end
			rap_pkg::PH_LEAD: begin
				if (b == 8'h00) begin
					phase_d = rap_pkg::PH_DONE;
				end else begin
					case (b[7:6])
						rap_pkg::LEAD_TYPE: phase_d = (type_sum[8] || fin) ?
							rap_pkg::PH_HALT : rap_pkg::PH_LEAD;
						rap_pkg::LEAD_RID: phase_d = fin ? rap_pkg::PH_HALT : rap_pkg::PH_RID;
						rap_pkg::LEAD_LEN: phase_d = fin ? rap_pkg::PH_HALT : rap_pkg::PH_LEN1;
						default: phase_d = rap_pkg::PH_HALT;
					endcase
				end
			end
			rap_pkg::PH_RID: begin
				phase_d = (rid_sum[16] || fin) ? rap_pkg::PH_HALT : rap_pkg::PH_LEAD;
			end
			rap_pkg::PH_LEN1: begin
				phase_d = fin ? rap_pkg::PH_HALT : rap_pkg::PH_LEN2;
			end
			rap_pkg::PH_LEN2: begin
				phase_d = fin ? rap_pkg::PH_HALT : rap_pkg::PH_DATA;
			end
			rap_pkg::PH_DATA: begin
				if (fin || (is_last && res_inc[16])) begin
					phase_d = rap_pkg::PH_HALT;
				end else if (is_last) begin
					phase_d = rap_pkg::PH_LEAD;
				end
			end
			default: phase_d = phase_q;
		endcase
	end

	// datapath and entry
	always_comb begin
		cnt_d    = cnt_q;
		type_d   = type_q;
		res_d    = res_q;
		hdr_d    = hdr_q;
		left_d   = left_q;
		len_d    = len_q;
		push_raw = 1'b0;
		ent      = '0;
		case (phase_q)
			rap_pkg::PH_SIG: begin
				if (!sig_ok) begin
					push_raw = 1'b1;
					ent.kind = rap_pkg::KIND_ERROR;
					ent.err  = rap_pkg::ERR_SIG;
				end else if (fin) begin
					push_raw = 1'b1;
					ent.kind = rap_pkg::KIND_ERROR;
					ent.err  = (cnt_q == 2'd3) ? rap_pkg::ERR_TRUNC : rap_pkg::ERR_SIG;
				end else if (cnt_q != 2'd3) begin
					cnt_d = cnt_q + 2'd1;
				end
			end
			rap_pkg::PH_LEAD: begin
				if (b == 8'h00) begin
					push_raw = 1'b1;
					ent.kind = rap_pkg::KIND_END;
				end else begin
					case (b[7:6])
						rap_pkg::LEAD_TYPE: begin
							if (type_sum[8]) begin
								push_raw = 1'b1;
								ent.kind = rap_pkg::KIND_ERROR;
								ent.err  = rap_pkg::ERR_TYPE;
							end else begin
								type_d = type_sum[7:0];
								res_d  = 16'd1;
								if (fin) begin
									push_raw = 1'b1;
									ent.kind = rap_pkg::KIND_ERROR;
									ent.err  = rap_pkg::ERR_TRUNC;
								end
							end
						end
						rap_pkg::LEAD_RID, rap_pkg::LEAD_LEN: begin
							hdr_d = {8'h00, b[5:0]};
							if (fin) begin
								push_raw = 1'b1;
								ent.kind = rap_pkg::KIND_ERROR;
								ent.err  = rap_pkg::ERR_TRUNC;
							end
						end
						default: begin
							push_raw = 1'b1;
							ent.kind = rap_pkg::KIND_ERROR;
							ent.err  = rap_pkg::ERR_LEAD;
						end
					endcase
				end
			end
			rap_pkg::PH_RID: begin
				if (rid_sum[16]) begin
					push_raw = 1'b1;
					ent.kind = rap_pkg::KIND_ERROR;
					ent.err  = rap_pkg::ERR_ID;
				end else begin
					res_d = rid_sum[15:0];
					if (fin) begin
						push_raw = 1'b1;
						ent.kind = rap_pkg::KIND_ERROR;
						ent.err  = rap_pkg::ERR_TRUNC;
					end
				end
			end
			rap_pkg::PH_LEN1: begin
				hdr_d = {hdr_q[5:0], b};
				if (fin) begin
					push_raw = 1'b1;
					ent.kind = rap_pkg::KIND_ERROR;
					ent.err  = rap_pkg::ERR_TRUNC;
				end
			end
			rap_pkg::PH_LEN2: begin
				len_d  = len_new;
				left_d = len_new;
				if (fin) begin
					push_raw = 1'b1;
					ent.kind = rap_pkg::KIND_ERROR;
					ent.err  = rap_pkg::ERR_TRUNC;
				end
			end
			rap_pkg::PH_DATA: begin
				push_raw       = 1'b1;
				ent.kind       = rap_pkg::KIND_DATA;
				ent.res1       = res_q;
				ent.data_byte  = b;
				ent.first      = is_first;
				ent.last       = is_last;
				ent.length     = len_q;
				if (is_last) begin
					left_d = '0;
					if (res_inc[16]) begin
						ent.two  = 1'b1;
						ent.err2 = rap_pkg::ERR_ID;
					end else begin
						res_d = res_inc[15:0];
						if (fin) begin
							ent.two  = 1'b1;
							ent.err2 = rap_pkg::ERR_TRUNC;
						end
					end
				end else begin
					left_d = left_q - 23'd1;
					if (fin) begin
						ent.two  = 1'b1;
						ent.err2 = rap_pkg::ERR_TRUNC;
					end
				end
			end
			default: push_raw = 1'b0;
		endcase
		ent.type_id = type_d;
		ent.res2    = res_d;
		if (ent.kind != rap_pkg::KIND_DATA) begin
			ent.res1 = res_d;
		end
	end

	assign push       = accept && push_raw;
	assign push_entry = ent;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= rap_pkg::PH_SIG;
			cnt_q   <= '0;
			type_q  <= 8'd1;
			res_q   <= 16'd1;
			hdr_q   <= '0;
			left_q  <= '0;
			len_q   <= '0;
		end else if (accept) begin
			phase_q <= phase_d;
			cnt_q   <= cnt_d;
			type_q  <= type_d;
			res_q   <= res_d;
			hdr_q   <= hdr_d;
			left_q  <= left_d;
			len_q   <= len_d;
		end
	end

endmodule

`default_nettype wire

// ===== hw/rtl/rap_queue.sv =====
// rap_queue: short entry queue between parser and result emitter
// depends on rap_pkg
`default_nettype none

module rap_queue #(
	parameter int Depth = rap_pkg::QUEUE_DEPTH
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             push,
	input  wire rap_pkg::entry_t  push_entry,
	input  wire logic             pop,
	output rap_pkg::entry_t       head,
	output logic                  empty,
	output logic                  full
);

	localparam int PW = (Depth > 1) ? $clog2(Depth) : 1;
	localparam int CW = $clog2(Depth + 1);

	rap_pkg::entry_t slot_q [Depth];
	logic [PW-1:0] wr_q;
	logic [PW-1:0] rd_q;
	logic [CW-1:0] count_q;
	logic          do_push;
	logic          do_pop;

	assign empty   = (count_q == '0);
	assign full    = (count_q == CW'(Depth));
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign head    = slot_q[rd_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			slot_q[wr_q] <= push_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= '0;
			rd_q    <= '0;
			count_q <= '0;
		end else begin
			if (do_push) begin
				wr_q <= (wr_q == PW'(Depth - 1)) ? '0 : wr_q + PW'(1);
			end
			if (do_pop) begin
				rd_q <= (rd_q == PW'(Depth - 1)) ? '0 : rd_q + PW'(1);
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + CW'(1);
			end else if (do_pop && !do_push) begin
				count_q <= count_q - CW'(1);
			end
		end
	end

endmodule

`default_nettype wire

// ===== hw/rtl/rap_back.sv =====
// rap_back: emits one or two results per queue entry through an output register
// depends on rap_pkg
`default_nettype none

module rap_back (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire rap_pkg::entry_t  head,
	input  wire logic             empty,
	output logic                  pop,
	output logic                  result_valid,
	input  wire logic             result_stall,
	output rap_pkg::result_t      result
);

	logic             valid_q;
	logic             sub_q;
	rap_pkg::result_t res_q;
	rap_pkg::result_t next_res;
	logic             load;

	assign load = !valid_q || !result_stall;
	assign pop  = load && !empty && (!head.two || sub_q);

	always_comb begin
		next_res = '0;
		next_res.type_id = head.type_id;
		if (sub_q) begin
			next_res.kind        = rap_pkg::KIND_ERROR;
			next_res.resource_id = head.res2;
			next_res.error_code  = head.err2;
		end else begin
			next_res.kind              = head.kind;
			next_res.resource_id       = head.res1;
			next_res.data_byte         = head.data_byte;
			next_res.first_of_resource = head.first;
			next_res.last_of_resource  = head.last;
			next_res.resource_length   = head.length;
			next_res.error_code        = head.err;
		end
	end

	always_ff @(posedge clk) begin
		if (load && !empty) begin
			res_q <= next_res;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			sub_q   <= 1'b0;
		end else if (load) begin
			valid_q <= !empty;
			if (!empty) begin
				sub_q <= head.two && !sub_q;
			end
		end
	end

	assign result_valid = valid_q;
	assign result       = res_q;

endmodule

`default_nettype wire
